/* sv/whash_pkg.sv */
// whash_pkg: constants, command/status types and helpers for the word stream hash
// used by whash_ctrl, whash_datapath and word_stream_hash64_core
// no dependencies
`default_nettype none

package whash_pkg;

    localparam int WORD_W = 32;
    localparam int HASH_W = 64;

    // lane start values and multipliers, finalization multipliers and reset seed
    localparam logic [WORD_W-1:0] LANE_ONE_INIT = 32'h91eb9dc7;
    localparam logic [WORD_W-1:0] LANE_TWO_INIT = 32'h41c6ce57;
    localparam logic [WORD_W-1:0] LANE_ONE_MUL  = 32'd2654435761;
    localparam logic [WORD_W-1:0] LANE_TWO_MUL  = 32'd1597334677;
    localparam logic [WORD_W-1:0] FIN_MUL_A     = 32'd2246822507;
    localparam logic [WORD_W-1:0] FIN_MUL_B     = 32'd3266489909;
    localparam logic [WORD_W-1:0] SEED_RESET    = 32'h3fc0b49e;

    // controller to datapath
    typedef struct packed {
        logic absorb;       // fold one input word into both lanes
        logic fin_capture;  // first finalization round, register products
        logic out_load;     // second round, load result and reload lanes
        logic cfg_write;    // take new seed, reload lanes
    } whash_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;     // result register empty or being drained
    } whash_status_t;

    // product modulo 2^32
    function automatic logic [WORD_W-1:0] mul32(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
        logic [2*WORD_W-1:0] prod;
        prod = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        return prod[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/whash_ctrl.sv */
// whash_ctrl: sequencer for word absorb and the two finalization rounds
// depends on whash_pkg
`default_nettype none

module whash_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_last_word,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  whash_pkg::whash_status_t     status,
    output whash_pkg::whash_cmd_t        cmd
);
    import whash_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIN1,
        ST_FIN2
    } state_t;

    state_t state_reg, state_next;

    // handshakes and commands, a seed write takes priority over a word
    always_comb begin
        s_ready         = (state_reg == ST_IDLE) && !cfg_valid;
        cfg_ready       = (state_reg == ST_IDLE);
        cmd.cfg_write   = cfg_valid && (state_reg == ST_IDLE);
        cmd.absorb      = s_valid && (state_reg == ST_IDLE) && !cmd.cfg_write;
        cmd.fin_capture = (state_reg == ST_FIN1);
        cmd.out_load    = (state_reg == ST_FIN2) && status.out_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.absorb && s_last_word) begin
                    state_next = ST_FIN1;
                end
            end
            ST_FIN1: begin
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* sv/whash_datapath.sv */
// whash_datapath: seed, the two hash lanes, finalization products and result register
// depends on whash_pkg
`default_nettype none

module whash_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  whash_pkg::whash_cmd_t              cmd,
    output whash_pkg::whash_status_t           status,
    input  wire logic [whash_pkg::WORD_W-1:0]  s_data_word,
    input  wire logic [whash_pkg::WORD_W-1:0]  cfg_seed,
    output logic      [whash_pkg::HASH_W-1:0]  m_hash_value,
    output logic                               m_valid,
    input  wire logic                          m_ready
);
    import whash_pkg::*;

    logic [WORD_W-1:0] seed_reg, seed_next;
    logic [WORD_W-1:0] lane_one_reg, lane_one_next;
    logic [WORD_W-1:0] lane_two_reg, lane_two_next;
    logic [WORD_W-1:0] p1_reg, p2_reg, p3_reg;
    logic [WORD_W-1:0] fin_a, fin_b;
    logic [HASH_W-1:0] hash_reg;
    logic              out_valid_reg, out_valid_next;

    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_hash_value    = hash_reg;

    // second round: a from first-round products, b folds in the fresh a
    always_comb begin
        fin_a = p1_reg ^ p2_reg;
        fin_b = p3_reg ^ mul32(fin_a ^ (fin_a >> 13), FIN_MUL_B);
    end

    // seed and lane update
    always_comb begin
        seed_next     = seed_reg;
        lane_one_next = lane_one_reg;
        lane_two_next = lane_two_reg;
        if (cmd.cfg_write) begin
            seed_next     = cfg_seed;
            lane_one_next = LANE_ONE_INIT ^ cfg_seed;
            lane_two_next = LANE_TWO_INIT ^ cfg_seed;
        end else if (cmd.absorb) begin
            lane_one_next = mul32(lane_one_reg ^ s_data_word, LANE_ONE_MUL);
            lane_two_next = mul32(lane_two_reg ^ s_data_word, LANE_TWO_MUL);
        end else if (cmd.out_load) begin
            lane_one_next = LANE_ONE_INIT ^ seed_reg;
            lane_two_next = LANE_TWO_INIT ^ seed_reg;
        end
    end

    // result valid flag
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control and lane registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= SEED_RESET;
            lane_one_reg  <= LANE_ONE_INIT ^ SEED_RESET;
            lane_two_reg  <= LANE_TWO_INIT ^ SEED_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            seed_reg      <= seed_next;
            lane_one_reg  <= lane_one_next;
            lane_two_reg  <= lane_two_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // first-round products and result payload
    always_ff @(posedge aclk) begin
        if (cmd.fin_capture) begin
            p1_reg <= mul32(lane_one_reg ^ (lane_one_reg >> 16), FIN_MUL_A);
            p2_reg <= mul32(lane_two_reg ^ (lane_two_reg >> 13), FIN_MUL_B);
            p3_reg <= mul32(lane_two_reg ^ (lane_two_reg >> 16), FIN_MUL_A);
        end
        if (cmd.out_load) begin
            hash_reg <= {fin_b, fin_a};
        end
    end

endmodule

`default_nettype wire

/* sv/word_stream_hash64_core.sv */
// word_stream_hash64_core: 64-bit hash over a stream of 32-bit words
// top level, instantiates whash_ctrl and whash_datapath, depends on whash_pkg
//
// Usage:
//   Input channel s_*: one 32-bit word per handshake, s_last_word marks the
//   final word of a message. Result channel m_*: one 64-bit hash per message,
//   upper half the second-round value b, lower half a. Config channel cfg_*:
//   writes the seed and reloads both lanes, dropping any partly hashed message.
// Throughput: a word that is not last is absorbed with two parallel
//   32x32 multipliers in the lane feedback loop, so such words stream at one
//   per cycle while no seed write or finalization is pending. A last word is
//   absorbed, then two finalization rounds follow, because the second round
//   multiplies a value formed from the products of the first.
// Finalization: first-round products are registered, then the result is loaded.
// Reset: aresetn (synchronous, active low) sets the seed to its default,
//   loads the lanes and empties the result register.
// Stall: the result sits in an output register; further words are taken
//   while it waits, and only the next message's second finalization round
//   holds until the receiver takes the pending hash.
`default_nettype none

module word_stream_hash64_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [whash_pkg::WORD_W-1:0]  s_data_word,
    input  wire logic                          s_last_word,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [whash_pkg::HASH_W-1:0]  m_hash_value,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [whash_pkg::WORD_W-1:0]  cfg_seed
);
    import whash_pkg::*;

    whash_cmd_t    cmd;
    whash_status_t status;

    // sequencer
    whash_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_last_word (s_last_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // lanes, finalization and result register
    whash_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_data_word  (s_data_word),
        .cfg_seed     (cfg_seed),
        .m_hash_value (m_hash_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

endmodule

`default_nettype wire
